// ----- design/adsr_envelope_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the envelope generator
// Shared assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// consequent holds in the cycle after the antecedent
`define ADSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition holds at every clock edge out of reset
`define ADSR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- design/adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Envelope generator package
// Widths, event and phase codes, register indexes and the exp2 table.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int TIME_BITS  = 32;
  localparam int LEVEL_BITS = 16;
  localparam int LEN_BITS   = 20;
  localparam int SHAPE_BITS = 5;
  localparam int CFG_BITS   = 20;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [1:0] KIND_QUERY   = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [2:0] PH_ATTACK  = 3'd0;
  localparam logic [2:0] PH_DECAY   = 3'd1;
  localparam logic [2:0] PH_SUSTAIN = 3'd2;
  localparam logic [2:0] PH_RELEASE = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  localparam logic [2:0] REG_PEAK    = 3'd0;
  localparam logic [2:0] REG_SUS     = 3'd1;
  localparam logic [2:0] REG_ATTACK  = 3'd2;
  localparam logic [2:0] REG_DECAY   = 3'd3;
  localparam logic [2:0] REG_RELEASE = 3'd4;
  localparam logic [2:0] REG_ASHAPE  = 3'd5;
  localparam logic [2:0] REG_DSHAPE  = 3'd6;
  localparam logic [2:0] REG_RSHAPE  = 3'd7;

  localparam logic [17:0] LOG2E_Q16 = 18'd94548;

  typedef struct packed {
    logic        start;
    logic [57:0] num;
    logic [19:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [57:0] quo;
  } div_rsp_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    case (i)
      5'd0:  pow2_tab = 17'd65536;
      5'd1:  pow2_tab = 17'd62758;
      5'd2:  pow2_tab = 17'd60098;
      5'd3:  pow2_tab = 17'd57550;
      5'd4:  pow2_tab = 17'd55109;
      5'd5:  pow2_tab = 17'd52773;
      5'd6:  pow2_tab = 17'd50535;
      5'd7:  pow2_tab = 17'd48393;
      5'd8:  pow2_tab = 17'd46341;
      5'd9:  pow2_tab = 17'd44376;
      5'd10: pow2_tab = 17'd42495;
      5'd11: pow2_tab = 17'd40693;
      5'd12: pow2_tab = 17'd38968;
      5'd13: pow2_tab = 17'd37316;
      5'd14: pow2_tab = 17'd35734;
      5'd15: pow2_tab = 17'd34219;
      default: pow2_tab = 17'd32768;
    endcase
  endfunction

endpackage

// ----- design/adsr_divider.sv -----
// ----------------------------------------------------------------------------
// Envelope divider
// Restoring divider, one quotient bit per cycle, 58-bit dividend.
// ----------------------------------------------------------------------------
module adsr_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  adsr_pkg::div_req_t req,
  output adsr_pkg::div_rsp_t rsp
);

  logic [57:0] quo_r, quo_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic [19:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [20:0] trial;
  logic [20:0] shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[19:0], quo_r[57]};
    trial    = shifted - {1'b0, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'd57;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[56:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[56:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- design/adsr_envelope_generator.sv -----
// Items in sustain or once done go from S_CLASS and S_PREP straight to S_OUT; a linear
// phase adds S_DIV, the 58-step divider, and an exponential one adds S_EXP1, S_EXP2
// and S_BLEND after it. in_ready is low while an item is worked and while its result
// waits; the next item is taken in the cycle after the result is delivered at the
// earliest. Reset (synchronous, rst_n low) loads the register defaults, start time zero
// and an open-ended sustain.
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Event-driven envelope level with linear or exponential phases.
// ----------------------------------------------------------------------------
`include "adsr_envelope_generator_macros.svh"

module adsr_envelope_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_level,
  output logic [2:0]  out_phase,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLASS = 8'b0000_0010,
    S_PREP  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_EXP1  = 8'b0001_0000,
    S_EXP2  = 8'b0010_0000,
    S_BLEND = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] peak_r, sus_r;
  logic [19:0] alen_r, dlen_r, rlen_r;
  logic [4:0]  ashape_r, dshape_r, rshape_r;
  logic [31:0] start_r, suslen_r;
  logic [1:0]  kind_r;
  logic [31:0] now_r;
  logic [31:0] t_r;
  logic [2:0]  ph_r;
  logic [19:0] p_r, len_r;
  logic [4:0]  shape_r;
  logic        expo_r;
  logic [57:0] y_r;
  logic [16:0] e_r;
  logic [15:0] lvl_r;
  logic [15:0] olvl_r;
  logic [2:0]  oph_r;
  logic        ovalid_r;

  adsr_pkg::div_req_t dreq;
  adsr_pkg::div_rsp_t drsp;

  adsr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [32:0] end_d;
  logic [31:0] suslen_new;
  logic [31:0] t_now;
  logic [38:0] xmul;
  logic [16:0] ti, tj, mval;
  logic [29:0] dfm;
  logic [53:0] mix;
  logic [16:0] one_m_e;
  logic        out_stall;

  always_comb begin
    t_now = (now_r >= start_r) ? now_r - start_r : '0;
    end_d = {13'd0, alen_r} + {13'd0, dlen_r};
    suslen_new = (t_r < end_d[31:0]) ? 32'd0 : t_r - end_d[31:0];
    xmul = {18'd0, y_r[20:0]} * {21'd0, adsr_pkg::LOG2E_Q16};
    ti = adsr_pkg::pow2_tab({1'b0, y_r[15:12]});
    tj = adsr_pkg::pow2_tab({1'b0, y_r[15:12]} + 5'd1);
    dfm = {13'd0, ti - tj} * {18'd0, y_r[11:0]};
    mval = ti - dfm[28:12];
    one_m_e = 17'd65536 - e_r;
  end

  always_comb begin
    state_nxt = state_r;
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = len_r;
    mix = '0;
    unique case (state_r)
      S_IDLE:  if (in_valid && !ovalid_r) state_nxt = S_CLASS;
      S_CLASS: state_nxt = S_PREP;
      S_PREP: begin
        if (ph_r == adsr_pkg::PH_SUSTAIN || ph_r == adsr_pkg::PH_DONE) begin
          state_nxt = S_OUT;
        end else begin
          dreq.start = 1'b1;
          if (expo_r) dreq.num = {17'd0, {5'd0, p_r} * {20'd0, shape_r}, 16'd0};
          else if (ph_r == adsr_pkg::PH_ATTACK)
            dreq.num = {22'd0, {20'd0, peak_r} * {16'd0, p_r}};
          else if (ph_r == adsr_pkg::PH_DECAY)
            dreq.num = {21'd0, {1'b0, {20'd0, sus_r} * {16'd0, p_r}} +
                               {1'b0, {20'd0, peak_r} * {16'd0, len_r - p_r}}};
          else dreq.num = {22'd0, {20'd0, sus_r} * {16'd0, len_r - p_r}};
          state_nxt = S_DIV;
        end
      end
      S_DIV:   if (drsp.done) state_nxt = expo_r ? S_EXP1 : S_OUT;
      S_EXP1:  state_nxt = S_EXP2;
      S_EXP2:  state_nxt = S_BLEND;
      S_BLEND: state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (ph_r == adsr_pkg::PH_ATTACK)
      mix = {21'd0, {17'd0, peak_r} * {16'd0, one_m_e}};
    else if (ph_r == adsr_pkg::PH_DECAY)
      mix = {20'd0, {18'd0, sus_r} * {17'd0, one_m_e} + {18'd0, peak_r} * {17'd0, e_r}};
    else mix = {21'd0, {17'd0, sus_r} * {16'd0, e_r}};
  end

  assign in_ready = (state_r == S_IDLE) && !ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      peak_r   <= 16'd65535;
      sus_r    <= 16'd32768;
      alen_r   <= 20'd100;
      dlen_r   <= 20'd100;
      rlen_r   <= 20'd100;
      ashape_r <= 5'd5;
      dshape_r <= 5'd10;
      rshape_r <= 5'd1;
      start_r  <= '0;
      suslen_r <= '1;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          adsr_pkg::REG_PEAK:    peak_r   <= cfg_data[15:0];
          adsr_pkg::REG_SUS:     sus_r    <= cfg_data[15:0];
          adsr_pkg::REG_ATTACK:  alen_r   <= cfg_data;
          adsr_pkg::REG_DECAY:   dlen_r   <= cfg_data;
          adsr_pkg::REG_RELEASE: rlen_r   <= cfg_data;
          adsr_pkg::REG_ASHAPE:  ashape_r <= cfg_data[4:0];
          adsr_pkg::REG_DSHAPE:  dshape_r <= cfg_data[4:0];
          default:               rshape_r <= cfg_data[4:0];
        endcase
      end
      if (state_r == S_IDLE && in_valid && !ovalid_r) begin
        kind_r <= in_kind;
        now_r  <= in_time_ms;
        if (in_kind == adsr_pkg::KIND_START) begin
          start_r  <= in_time_ms;
          suslen_r <= '1;
        end
      end
      if (state_r == S_CLASS) begin
        t_r <= t_now;
      end
      if (state_r == S_PREP && kind_r == adsr_pkg::KIND_RELEASE) begin
        suslen_r <= suslen_new;
      end
      if (state_r == S_OUT) begin
        ovalid_r <= 1'b1;
        oph_r    <= ph_r;
        olvl_r   <= (lvl_r > peak_r) ? peak_r : lvl_r;
      end else if (ovalid_r && out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (state_r == S_PREP) begin
      if (ph_r == adsr_pkg::PH_SUSTAIN) lvl_r <= sus_r;
      else lvl_r <= '0;
    end
    if (state_r == S_DIV && drsp.done) begin
      y_r   <= drsp.quo;
      lvl_r <= drsp.quo[15:0];
    end
    if (state_r == S_EXP1) y_r <= {35'd0, xmul[38:16]};
    if (state_r == S_EXP2) e_r <= (y_r[57:16] >= 42'd17) ? 17'd0 : (mval >> y_r[20:16]);
    if (state_r == S_BLEND) lvl_r <= (mix[32:16] > 17'h0FFFF) ? 16'hFFFF : mix[31:16];
  end

  // phase classification in S_CLASS, ready at S_PREP entry, uses t_now and, for a release, the new sustain length
  always_ff @(posedge clk) begin
    if (state_r == S_CLASS) begin : cls
      logic [31:0] tt;
      logic [32:0] es_raw, er_raw;
      logic [31:0] es, er, sl;
      tt = t_now;
      sl = (kind_r == adsr_pkg::KIND_RELEASE) ?
           ((tt < end_d[31:0]) ? 32'd0 : tt - end_d[31:0]) : suslen_r;
      es_raw = end_d + {1'b0, sl};
      es = es_raw[32] ? '1 : es_raw[31:0];
      er_raw = {1'b0, es} + {13'd0, rlen_r};
      er = er_raw[32] ? '1 : er_raw[31:0];
      if (tt < {12'd0, alen_r}) begin
        ph_r <= adsr_pkg::PH_ATTACK; p_r <= tt[19:0]; len_r <= alen_r;
        shape_r <= ashape_r; expo_r <= (ashape_r >= 5'd5);
      end else if (tt < end_d[31:0]) begin
        ph_r <= adsr_pkg::PH_DECAY; p_r <= tt[19:0] - alen_r; len_r <= dlen_r;
        shape_r <= dshape_r; expo_r <= (dshape_r >= 5'd5);
      end else if (tt < es) begin
        ph_r <= adsr_pkg::PH_SUSTAIN; p_r <= '0; len_r <= dlen_r;
        shape_r <= '0; expo_r <= 1'b0;
      end else if (tt < er) begin
        ph_r <= adsr_pkg::PH_RELEASE; p_r <= tt[19:0] - es[19:0]; len_r <= rlen_r;
        shape_r <= rshape_r; expo_r <= (rshape_r >= 5'd6);
      end else begin
        ph_r <= adsr_pkg::PH_DONE; p_r <= '0; len_r <= rlen_r;
        shape_r <= '0; expo_r <= 1'b0;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_level = olvl_r;
  assign out_phase = oph_r;
  assign out_stall = ovalid_r && !out_ready;

  `ADSR_ASSERT_ALWAYS(a_ready_idle, clk, rst_n, !in_ready || state_r == S_IDLE, "ready while busy")
  `ADSR_ASSERT_ALWAYS(a_phase_range, clk, rst_n, !ovalid_r || oph_r <= adsr_pkg::PH_DONE, "bad phase")
  `ADSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, ovalid_r && $stable(olvl_r), "item dropped")

endmodule
